// ----- rtl/core/ppf_pkg.sv -----
// ppf_pkg: shared sizes, command codes, item structs and control/status types
// for the point-in-polygon filter; no dependencies
package ppf_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 24;
	localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_TEST   = 2'd2;

	typedef struct packed {
		logic [1:0]                   command;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
	} ppf_req_t;

	typedef struct packed {
		logic              inside_res;
		logic [VCNT_W-1:0] vertices_held;
	} ppf_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} ppf_state_t;

	typedef struct packed {
		logic              clear;
		logic              append;
		logic              load_point;
		logic              rd_en;
		logic              rd_prime;
		logic [VIDX_W-1:0] rd_addr;
		logic              finish;
	} ppf_ctl_t;

	typedef struct packed {
		logic [VCNT_W-1:0] count;
		logic              pipe_busy;
	} ppf_status_t;

endpackage

// ----- rtl/core/ppf_datapath.sv -----
// ppf_datapath: vertex tables, point registers and the three-stage edge pipeline
// depends on ppf_pkg
module ppf_datapath
	import ppf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ppf_req_t    request,
	input  ppf_ctl_t    ctl,
	output ppf_status_t status,
	output logic        done,
	output ppf_res_t    result
);

	logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

	logic [VCNT_W-1:0]            count_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;
	logic signed [COORD_BITS-1:0] old_x_q, old_y_q;
	logic                         rdv_q, prime_q;
	logic                         valid_s1, cond_s1;
	logic signed [DIFF_W-1:0]     a_s1, b_s1, c_s1, d_s1;
	logic                         valid_s2, cond_s2;
	logic signed [PROD_W-1:0]     p1_s2, p2_s2;
	logic                         inside_q;
	logic                         done_q;
	ppf_res_t                     result_q;

	// vertex tables
	always_ff @(posedge clk) begin
		if (ctl.append && (count_q < VCNT_W'(MAX_VERTICES))) begin
			mem_x[count_q[VIDX_W-1:0]] <= request.coord_x;
			mem_y[count_q[VIDX_W-1:0]] <= request.coord_y;
		end
		if (ctl.rd_en) begin
			rd_x_q <= mem_x[ctl.rd_addr];
			rd_y_q <= mem_y[ctl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.append && (count_q < VCNT_W'(MAX_VERTICES))) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_point) begin
			px_q <= request.coord_x;
			py_q <= request.coord_y;
		end
	end

	// edge setup from the returned vertex and the previous one
	logic                         swap;
	logic                         cond;
	logic signed [COORD_BITS-1:0] x1, x2, y1, y2;

	always_comb begin
		swap = rd_x_q > old_x_q;
		x1   = swap ? old_x_q : rd_x_q;
		x2   = swap ? rd_x_q  : old_x_q;
		y1   = swap ? old_y_q : rd_y_q;
		y2   = swap ? rd_y_q  : old_y_q;
		cond = (rd_x_q < px_q) == (px_q <= old_x_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q    <= 1'b0;
			prime_q  <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			rdv_q    <= ctl.rd_en;
			prime_q  <= ctl.rd_prime;
			valid_s1 <= rdv_q && !prime_q;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdv_q) begin
			old_x_q <= rd_x_q;
			old_y_q <= rd_y_q;
		end
		cond_s1 <= cond;
		a_s1    <= $signed({py_q[COORD_BITS-1], py_q}) - $signed({y1[COORD_BITS-1], y1});
		b_s1    <= $signed({x2[COORD_BITS-1], x2}) - $signed({x1[COORD_BITS-1], x1});
		c_s1    <= $signed({y2[COORD_BITS-1], y2}) - $signed({y1[COORD_BITS-1], y1});
		d_s1    <= $signed({px_q[COORD_BITS-1], px_q}) - $signed({x1[COORD_BITS-1], x1});
		cond_s2 <= cond_s1;
		p1_s2   <= a_s1 * b_s1;
		p2_s2   <= c_s1 * d_s1;
	end

	// crossing parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (ctl.load_point) begin
			inside_q <= 1'b0;
		end else if (valid_s2 && cond_s2 && (p1_s2 < p2_s2)) begin
			inside_q <= !inside_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			result_q.inside_res    <= inside_q && (count_q != '0);
			result_q.vertices_held <= count_q;
		end
	end

	assign status.count     = count_q;
	assign status.pipe_busy = rdv_q || valid_s1 || valid_s2;
	assign done             = done_q;
	assign result           = result_q;

endmodule

// ----- rtl/core/ppf_ctrl.sv -----
// ppf_ctrl: command decode and edge-walk sequencer for the point-in-polygon filter
// depends on ppf_pkg
module ppf_ctrl
	import ppf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  command,
	input  ppf_status_t status,
	output logic        busy,
	output ppf_ctl_t    ctl
);

	ppf_state_t        state_q, state_d;
	logic [VIDX_W-1:0] idx_q, idx_d;
	logic [VIDX_W-1:0] last_idx;

	assign last_idx = VIDX_W'(status.count - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (command)
						CMD_CLEAR:  ctl.clear  = 1'b1;
						CMD_APPEND: ctl.append = 1'b1;
						CMD_TEST: begin
							ctl.load_point = 1'b1;
							if (status.count == '0) begin
								ctl.finish = 1'b1;
							end else begin
								// prime with the closing vertex
								ctl.rd_en    = 1'b1;
								ctl.rd_prime = 1'b1;
								ctl.rd_addr  = last_idx;
								idx_d        = '0;
								state_d      = ST_WALK;
							end
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_addr = idx_q;
				if (idx_q == last_idx) begin
					state_d = ST_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (status.count != '0))
		else $error("edge walk with an empty polygon");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> ({1'b0, idx_q} < status.count))
		else $error("vertex index past the held count");

	a_drain_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_DRAIN || state_q == ST_IDLE))
		else $error("drain left for a state other than idle");

	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && $past(state_q) == ST_IDLE) |-> (idx_q == '0))
		else $error("edge walk did not start at the first vertex");

endmodule

// ----- rtl/core/point_in_polygon_filter.sv -----
// point_in_polygon_filter: top level joining the sequencer and the datapath
// depends on ppf_pkg, ppf_ctrl, ppf_datapath
// clear, append and ignored commands leave busy low
// test with n vertices held: busy through the edge walk and the pipeline drain, then the result
//   strobe follows; the edge walk reads one vertex per cycle from the tables
// test on an empty polygon: result strobe in the cycle after acceptance
// results are a one-cycle done strobe; the receiver cannot stall
// reset clears the vertex count and control; vertex tables are not cleared
module point_in_polygon_filter
	import ppf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ppf_req_t request,
	output logic     busy,
	output logic     done,
	output ppf_res_t result
);

	// command and status between the sequencer and the datapath
	ppf_ctl_t    ctl;
	ppf_status_t status;

	// sequencer: decodes each accepted item and walks the edges of a test
	ppf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.status  (status),
		.busy    (busy),
		.ctl     (ctl)
	);

	// datapath: vertex tables, edge pipeline, parity and result register
	ppf_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctl     (ctl),
		.status  (status),
		.done    (done),
		.result  (result)
	);

	// a result never shows while a walk is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a walk only starts from an accepted test item
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && request.command == CMD_TEST))
		else $error("busy without a test item");

	// vertex count never exceeds the table depth
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= VCNT_W'(MAX_VERTICES))
		else $error("vertex count past capacity");

endmodule
